// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define DCG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define DCG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dcg_pkg.sv
// Types, constants and queue entry layout of the double-cell glyph line compactor.
package dcg_pkg;

    localparam int MAX_COLUMNS_DEF = 4096;
    localparam int CHAR_W          = 16;
    localparam int ATTR_W          = 16;
    localparam int COL_W           = 12;
    localparam int REP_W           = 13;
    localparam int QDEPTH          = 4;

    localparam int LEAD_BIT  = 8;
    localparam int TRAIL_BIT = 9;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ATTR_W-1:0] t_attr;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [REP_W-1:0]  t_rep;

    localparam t_char FILL_CHAR = 16'h0020;

    // One queue entry holds everything an accepted item produces: an optional
    // cell result and an optional fill result.
    typedef struct packed {
        logic  emit_cell;
        logic  has_fill;
        logic  row_end;
        logic  cursor_valid;
        t_col  cursor_out;
        t_char cell_char;
        t_attr cell_attr;
        t_attr fill_attr;
        t_rep  fill_count;
    } t_entry;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic {
        BK_FIRST,
        BK_FILL
    } t_back_state;

endpackage

// File: rtl/dcg_in_if.sv
// Input cell channel: valid/ready handshake with the cell fields.
interface dcg_in_if;
    import dcg_pkg::*;

    logic  valid;
    logic  ready;
    t_char cell_char;
    t_attr cell_attr;
    logic  row_last;
    logic  cursor_here;
    t_col  cursor_column;

    modport source (
        output valid, cell_char, cell_attr, row_last, cursor_here, cursor_column,
        input  ready
    );
    modport sink (
        input  valid, cell_char, cell_attr, row_last, cursor_here, cursor_column,
        output ready
    );
endinterface

// File: rtl/dcg_out_if.sv
// Result channel: valid/ready handshake with the result fields.
interface dcg_out_if;
    import dcg_pkg::*;

    logic  valid;
    logic  ready;
    t_char out_char;
    t_attr out_attr;
    t_rep  repeat_count;
    logic  row_end;
    logic  cursor_valid;
    t_col  cursor_out;

    modport source (
        output valid, out_char, out_attr, repeat_count, row_end, cursor_valid, cursor_out,
        input  ready
    );
    modport sink (
        input  valid, out_char, out_attr, repeat_count, row_end, cursor_valid, cursor_out,
        output ready
    );
    modport monitor (
        input valid, ready, out_char, out_attr, repeat_count, row_end, cursor_valid,
              cursor_out
    );
endinterface

// File: rtl/double_cell_glyph_line_compactor.sv
// An accepted cell's entry is written into the queue, then loaded into the output
// register once that is free. Throughput: one cell per cycle while the queue is
// not full; a row-end cell with drops after an emitted cell gives two results,
// which leave the single output register one per cycle while the output is ready.
// A four-entry queue between the front counters and the output stage absorbs those.
// Reset (synchronous, i_rst_n low) turns the mode off, clears row state, queue and
// output valid.
module double_cell_glyph_line_compactor #(
    parameter int MAX_COLUMNS = dcg_pkg::MAX_COLUMNS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    dcg_in_if.sink    i_cell_ch,
    dcg_out_if.source o_result_ch
);
    import dcg_pkg::*;

    logic      push, pop;
    t_entry    entry, head;
    t_q_status q_status;

    dcg_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cell_ch   (i_cell_ch),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_entry     (entry)
    );

    dcg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    dcg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_result_ch (o_result_ch)
    );
endmodule

// File: rtl/dcg_front.sv
// Front part: accepts cells, tracks wide glyphs and counters, builds queue entries.
module dcg_front #(
    parameter int MAX_COLUMNS = dcg_pkg::MAX_COLUMNS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    dcg_in_if.sink            i_cell_ch,
    input  dcg_pkg::t_q_status i_q_status,
    output logic              o_push,
    output dcg_pkg::t_entry   o_entry
);
    import dcg_pkg::*;

    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
    localparam int CMP_W = (CNT_W > COL_W) ? CNT_W : COL_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COLUMNS);

    logic             r_mode;
    logic             r_inside, n_inside;
    t_col             r_idx, n_idx;
    logic [CNT_W-1:0] r_drop, n_drop;
    logic [CNT_W-1:0] r_skip, n_skip;

    logic             accept;
    logic             lead, trail, here, last;
    t_col             col;
    logic             emit;
    t_attr            eattr;
    t_col             adj;
    t_entry           entry;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CNT_MAX) ? v + CNT_W'(1) : CNT_MAX;
    endfunction

    assign i_cell_ch.ready = !i_q_status.full;
    assign accept          = i_cell_ch.valid && i_cell_ch.ready;

    assign lead  = i_cell_ch.cell_attr[LEAD_BIT];
    assign trail = i_cell_ch.cell_attr[TRAIL_BIT];
    assign here  = i_cell_ch.cursor_here;
    assign last  = i_cell_ch.row_last;
    assign col   = i_cell_ch.cursor_column;

    always_comb begin
        n_inside = r_inside;
        n_drop   = r_drop;
        n_skip   = r_skip;
        n_idx    = (r_idx != '1) ? r_idx + COL_W'(1) : r_idx;
        emit     = 1'b0;
        eattr    = i_cell_ch.cell_attr;
        adj      = '0;
        entry    = '0;

        if (!r_mode) begin
            n_inside           = 1'b0;
            n_idx              = '0;
            n_drop             = '0;
            n_skip             = '0;
            entry.emit_cell    = 1'b1;
            entry.row_end      = last;
            entry.cursor_valid = last && here;
            entry.cursor_out   = (last && here) ? col : '0;
            entry.cell_char    = i_cell_ch.cell_char;
            entry.cell_attr    = i_cell_ch.cell_attr;
        end else begin
            if (r_inside) begin
                n_drop = sat_inc(r_drop);
                if (trail) begin
                    n_inside = 1'b0;
                end else if (here && (r_idx <= col)) begin
                    n_skip = sat_inc(r_skip);
                end
            end else if (lead) begin
                emit             = 1'b1;
                eattr[TRAIL_BIT] = 1'b1;
                n_inside         = 1'b1;
                // The cell after the leading one counts when it lies at or before the cursor.
                if (here && (r_idx < col)) begin
                    n_skip = sat_inc(r_skip);
                end
            end else begin
                emit = 1'b1;
            end

            if (CMP_W'(col) > CMP_W'(n_skip)) begin
                adj = col - COL_W'(n_skip);
            end

            entry.emit_cell = emit;
            entry.has_fill  = last && (n_drop != '0);
            entry.row_end   = last;
            entry.cell_char = i_cell_ch.cell_char;
            entry.cell_attr = eattr;
            entry.fill_attr = i_cell_ch.cell_attr;
            entry.fill_count = REP_W'(n_drop);
            if (last) begin
                entry.cursor_valid = here;
                entry.cursor_out   = here ? adj : '0;
                n_inside           = 1'b0;
                n_idx              = '0;
                n_drop             = '0;
                n_skip             = '0;
            end
        end
    end

    assign o_entry = entry;
    assign o_push  = accept && (entry.emit_cell || entry.row_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_inside <= 1'b0;
            r_idx    <= '0;
            r_drop   <= '0;
            r_skip   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_inside <= n_inside;
                r_idx    <= n_idx;
                r_drop   <= n_drop;
                r_skip   <= n_skip;
            end
        end
    end
endmodule

// File: rtl/dcg_queue.sv
// Short queue of entries between the front and back parts.
module dcg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dcg_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output dcg_pkg::t_entry    o_head,
    output dcg_pkg::t_q_status o_status
);
    import dcg_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_entry             r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_status.full  = (r_count == CNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end
endmodule

// File: rtl/dcg_back.sv
// Back part: turns queue entries into one or two result items in an output register.
module dcg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dcg_pkg::t_entry    i_head,
    input  dcg_pkg::t_q_status i_q_status,
    output logic               o_pop,
    dcg_out_if.source          o_result_ch
);
    import dcg_pkg::*;

    t_back_state r_state, n_state;
    logic        r_valid;
    t_char       r_char;
    t_attr       r_attr;
    t_rep        r_rep;
    logic        r_row_end;
    logic        r_cv;
    t_col        r_cur;

    logic        load;
    logic        send_cell;
    t_char       nx_char;
    t_attr       nx_attr;
    t_rep        nx_rep;
    logic        nx_row_end;
    logic        nx_cv;
    t_col        nx_cur;

    assign load      = !i_q_status.empty && (!r_valid || o_result_ch.ready);
    assign send_cell = (r_state == BK_FIRST) && i_head.emit_cell;

    // Next state: an entry with both a cell and a fill takes two loads.
    always_comb begin
        n_state = r_state;
        if (load) begin
            case (r_state)
                BK_FIRST: n_state = (i_head.emit_cell && i_head.has_fill) ? BK_FILL : BK_FIRST;
                BK_FILL:  n_state = BK_FIRST;
                default:  n_state = BK_FIRST;
            endcase
        end
    end

    // Outputs: the result item to load and whether the head entry is done.
    always_comb begin
        o_pop = load && !(send_cell && i_head.has_fill);
        if (send_cell) begin
            nx_char    = i_head.cell_char;
            nx_attr    = i_head.cell_attr;
            nx_rep     = REP_W'(1);
            nx_row_end = i_head.row_end && !i_head.has_fill;
            nx_cv      = nx_row_end && i_head.cursor_valid;
            nx_cur     = nx_row_end ? i_head.cursor_out : '0;
        end else begin
            nx_char    = FILL_CHAR;
            nx_attr    = i_head.fill_attr;
            nx_rep     = i_head.fill_count;
            nx_row_end = 1'b1;
            nx_cv      = i_head.cursor_valid;
            nx_cur     = i_head.cursor_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char    <= nx_char;
            r_attr    <= nx_attr;
            r_rep     <= nx_rep;
            r_row_end <= nx_row_end;
            r_cv      <= nx_cv;
            r_cur     <= nx_cur;
        end
    end

    assign o_result_ch.valid        = r_valid;
    assign o_result_ch.out_char     = r_char;
    assign o_result_ch.out_attr     = r_attr;
    assign o_result_ch.repeat_count = r_rep;
    assign o_result_ch.row_end      = r_row_end;
    assign o_result_ch.cursor_valid = r_cv;
    assign o_result_ch.cursor_out   = r_cur;
endmodule

// File: rtl/dcg_checker.sv
// Port-level checker for the compactor's result channel, bound to the top level.
`include "assert_macros.svh"

module dcg_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           i_ready,
    input dcg_pkg::t_char i_char,
    input dcg_pkg::t_attr i_attr,
    input dcg_pkg::t_rep  i_rep,
    input logic           i_row_end,
    input logic           i_cv,
    input dcg_pkg::t_col  i_cur
);
    import dcg_pkg::*;

    logic                           stalled;
    logic [CHAR_W+ATTR_W+REP_W-1:0] held;

    assign stalled = i_valid && !i_ready;
    assign held    = {i_char, i_attr, i_rep};

    `DCG_ASSERT_NXT(a_hold_stalled, stalled, i_valid && $stable(held), "stalled item changed")
    `DCG_ASSERT_IMP(a_cursor_zero, i_valid && !i_cv, i_cur == '0, "cursor shown without cursor")
    `DCG_ASSERT_IMP(a_cursor_row_end, i_valid && !i_row_end, !i_cv, "cursor before row end")
    `DCG_ASSERT_IMP(a_cell_single, i_valid && (i_char != FILL_CHAR), i_rep == REP_W'(1), "bad rep")
endmodule

bind double_cell_glyph_line_compactor dcg_checker u_dcg_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_result_ch.valid),
    .i_ready   (o_result_ch.ready),
    .i_char    (o_result_ch.out_char),
    .i_attr    (o_result_ch.out_attr),
    .i_rep     (o_result_ch.repeat_count),
    .i_row_end (o_result_ch.row_end),
    .i_cv      (o_result_ch.cursor_valid),
    .i_cur     (o_result_ch.cursor_out)
);

// File: bench/tb_double_cell_glyph_line_compactor.sv
// Self-checking testbench of the double-cell glyph line compactor with a run predictor.
module tb_double_cell_glyph_line_compactor;
    import dcg_pkg::*;

    localparam bit    MODE_PASS      = 1'b0;
    localparam bit    MODE_COLLAPSE  = 1'b1;
    localparam t_attr LEAD_MASK      = t_attr'(1) << LEAD_BIT;
    localparam t_attr TRAIL_MASK     = t_attr'(1) << TRAIL_BIT;
    localparam int    STALL_LIMIT    = 4000;
    localparam int    DRAIN_SLACK    = 8;
    localparam int    HOLD_CYCLES    = 300;
    localparam int    REPORT_LIMIT   = 10;
    localparam int    LONG_ROW_CELLS = 100;

    typedef struct packed {
        t_char ch;
        t_attr attr;
        logic  last;
        logic  here;
        t_col  col;
    } t_cell;

    typedef struct packed {
        t_char ch;
        t_attr attr;
        t_rep  rep;
        logic  row_end;
        logic  cur_valid;
        t_col  cur_col;
    } t_run;

    // Tracks the row state of the compactor and the runs it still owes.
    class t_row_tracker;
        bit   mode;
        bit   in_glyph;
        t_col cell_idx;
        t_rep dropped;
        t_rep skipped;
        t_run due_runs[$];
        int   failures;

        function new();
            mode     = MODE_PASS;
            failures = 0;
            clear_row();
        endfunction

        function void set_mode(bit m);
            mode = m;
        endfunction

        function void clear_row();
            in_glyph = 1'b0;
            cell_idx = '0;
            dropped  = '0;
            skipped  = '0;
        endfunction

        function t_rep sat_inc(t_rep v);
            return (v < t_rep'(MAX_COLUMNS_DEF)) ? t_rep'(v + 1'b1) : t_rep'(MAX_COLUMNS_DEF);
        endfunction

        function t_run make_run(t_char ch, t_attr attr, t_rep rep, bit row_end, bit cv,
                                t_col col);
            t_run r;
            r.ch        = ch;
            r.attr      = attr;
            r.rep       = rep;
            r.row_end   = row_end;
            r.cur_valid = cv;
            r.cur_col   = cv ? col : t_col'(0);
            return r;
        endfunction

        function string show(t_run r);
            return $sformatf("char=%h attr=%h rep=%0d end=%b cv=%b col=%0d",
                             r.ch, r.attr, r.rep, r.row_end, r.cur_valid, r.cur_col);
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function int pending();
            return due_runs.size();
        endfunction

        // Called for every accepted input cell.
        function void take_cell(t_cell c);
            bit    emit;
            t_attr eattr;
            t_col  adj;
            emit  = 1'b0;
            eattr = c.attr;
            if (mode == MODE_PASS) begin
                clear_row();
                due_runs.push_back(make_run(c.ch, c.attr, t_rep'(1), c.last,
                                            c.last & c.here, c.col));
                return;
            end
            if (in_glyph) begin
                dropped = sat_inc(dropped);
                if (c.attr[TRAIL_BIT]) begin
                    in_glyph = 1'b0;
                end else if (c.here && cell_idx <= c.col) begin
                    skipped = sat_inc(skipped);
                end
            end else if (c.attr[LEAD_BIT]) begin
                emit     = 1'b1;
                eattr    = c.attr | TRAIL_MASK;
                in_glyph = 1'b1;
                if (c.here && int'(cell_idx) + 1 <= int'(c.col))
                    skipped = sat_inc(skipped);
            end else begin
                emit = 1'b1;
            end
            if (cell_idx != '1)
                cell_idx = cell_idx + 1'b1;
            if (!c.last) begin
                if (emit)
                    due_runs.push_back(make_run(c.ch, eattr, t_rep'(1), 1'b0, 1'b0, '0));
                return;
            end
            adj = (c.col > skipped) ? t_col'(c.col - skipped) : t_col'(0);
            if (dropped != '0) begin
                if (emit)
                    due_runs.push_back(make_run(c.ch, eattr, t_rep'(1), 1'b0, 1'b0, '0));
                due_runs.push_back(make_run(FILL_CHAR, c.attr, dropped, 1'b1, c.here, adj));
            end else begin
                due_runs.push_back(make_run(c.ch, eattr, t_rep'(1), 1'b1, c.here, adj));
            end
            clear_row();
        endfunction

        // Called for every accepted result item.
        function void match_output(t_run got);
            t_run want;
            if (due_runs.size() == 0) begin
                flag({"unexpected result ", show(got)});
                return;
            end
            want = due_runs.pop_front();
            if (got.ch !== want.ch || got.attr !== want.attr || got.rep !== want.rep ||
                got.row_end !== want.row_end || got.cur_valid !== want.cur_valid ||
                got.cur_col !== want.cur_col)
                flag({"expected ", show(want), " got ", show(got)});
        endfunction

        function void flush_leftovers();
            while (due_runs.size() != 0)
                flag({"missing result ", show(due_runs.pop_front())});
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    dcg_in_if  cell_ch ();
    dcg_out_if run_ch ();

    t_row_tracker run_tracker = new();

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    bit hold_on  = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    double_cell_glyph_line_compactor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cell_ch   (cell_ch),
        .o_result_ch (run_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: random stall bursts, one long hold on request, none at the end.
    initial begin
        run_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_on  = 1'b1;
                run_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on = 1'b0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                run_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                run_ch.ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_run got;
        if (i_rst_n && run_ch.valid && run_ch.ready) begin
            got.ch        = run_ch.out_char;
            got.attr      = run_ch.out_attr;
            got.rep       = run_ch.repeat_count;
            got.row_end   = run_ch.row_end;
            got.cur_valid = run_ch.cursor_valid;
            got.cur_col   = run_ch.cursor_out;
            run_tracker.match_output(got);
        end
    end

    always @(posedge i_clk) begin
        if ((cell_ch.valid && cell_ch.ready) || (run_ch.valid && run_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_cell(input t_char ch, input t_attr at, input bit last, input bit here,
                             input t_col col);
        t_cell c;
        c.ch   = ch;
        c.attr = at;
        c.last = last;
        c.here = here;
        c.col  = col;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            cell_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        cell_ch.valid         <= 1'b1;
        cell_ch.cell_char     <= ch;
        cell_ch.cell_attr     <= at;
        cell_ch.row_last      <= last;
        cell_ch.cursor_here   <= here;
        cell_ch.cursor_column <= col;
        @(posedge i_clk);
        while (!cell_ch.ready) @(posedge i_clk);
        run_tracker.take_cell(c);
        items_sent++;
    endtask

    // Stop offering cells and let every owed run, and any cell still in flight, drain.
    task automatic settle();
        cell_ch.valid <= 1'b0;
        while (run_tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        run_tracker.set_mode(m);
    endtask

    // Mostly well-formed glyphs with random content; rows may end inside a glyph.
    task automatic send_row(input int len);
        bit    here;
        t_col  col;
        t_attr at;
        int    glyph_left;
        here = 1'($urandom_range(0, 1));
        col  = ($urandom_range(0, 3) == 0) ? t_col'($urandom)
                                           : t_col'($urandom_range(0, len + 1));
        glyph_left = 0;
        for (int i = 0; i < len; i++) begin
            at = t_attr'($urandom) & ~(LEAD_MASK | TRAIL_MASK);
            if (glyph_left > 0) begin
                glyph_left--;
                if (glyph_left == 0)
                    at = at | TRAIL_MASK;
            end else if ($urandom_range(0, 2) == 0) begin
                at = at | LEAD_MASK;
                glyph_left = $urandom_range(1, 3);
            end
            // Now and then raw attribute bits and a cursor that moves within the row.
            if ($urandom_range(0, 15) == 0)
                at = t_attr'($urandom);
            if ($urandom_range(0, 19) == 0)
                col = t_col'($urandom);
            send_cell(t_char'($urandom), at, i == len - 1, here, col);
        end
    endtask

    task automatic run_rows(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            send_row($urandom_range(1, 12));
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= 1'b0;
        cell_ch.valid         <= 1'b0;
        cell_ch.cell_char     <= '0;
        cell_ch.cell_attr     <= '0;
        cell_ch.row_last      <= 1'b0;
        cell_ch.cursor_here   <= 1'b0;
        cell_ch.cursor_column <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(MODE_PASS);

        // Pass-through with extreme field values.
        send_cell(16'h0000, 16'h0000, 1'b0, 1'b0, 12'h000);
        send_cell(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 12'hFFF);
        send_cell(16'h1234, 16'h0100, 1'b1, 1'b1, 12'hFFF);
        send_cell(16'h0041, 16'h0200, 1'b1, 1'b0, 12'h005);
        settle();
        write_mode(MODE_COLLAPSE);

        // A closed glyph in the middle of the row, cursor beyond it.
        send_cell(16'h0041, 16'h0007, 1'b0, 1'b1, 12'd4);
        send_cell(16'h4E2D, 16'h0107, 1'b0, 1'b1, 12'd4);
        send_cell(16'h0000, 16'h0007, 1'b0, 1'b1, 12'd4);
        send_cell(16'h0000, 16'h0207, 1'b0, 1'b1, 12'd4);
        send_cell(16'h0042, 16'hFCFF, 1'b1, 1'b1, 12'd4);
        // Row ends on the trailing cell; the cursor clamps at zero.
        send_cell(16'hFFFF, 16'h0300, 1'b0, 1'b1, 12'd1);
        send_cell(16'h0000, 16'hFDFF, 1'b0, 1'b1, 12'd1);
        send_cell(16'h0000, 16'h0200, 1'b1, 1'b1, 12'd1);
        // Leading cell is the last cell of the row.
        send_cell(16'h0043, 16'h0000, 1'b0, 1'b0, 12'd0);
        send_cell(16'h5B57, 16'h0100, 1'b1, 1'b0, 12'd0);
        // Glyph still open at the end of the row, with drops.
        send_cell(16'h5B57, 16'h0100, 1'b0, 1'b1, 12'hFFF);
        send_cell(16'h0000, 16'h0000, 1'b1, 1'b1, 12'hFFF);
        // Mode turned off in the middle of a row loses its pending drops.
        send_cell(16'h5B57, 16'h0100, 1'b0, 1'b1, 12'd7);
        send_cell(16'h0000, 16'h0000, 1'b0, 1'b1, 12'd7);
        settle();
        write_mode(MODE_PASS);
        send_cell(16'h0044, 16'h0000, 1'b1, 1'b1, 12'd7);
        settle();
        write_mode(MODE_COLLAPSE);
        send_cell(16'h0045, 16'h0000, 1'b1, 1'b1, 12'd0);

        run_rows(80);
        // Hold the result side off while cells keep coming, so the block backs up.
        cell_ch.valid <= 1'b0;
        hold_req = 1'b1;
        @(posedge i_clk);
        wait (hold_on);
        run_rows(40);
        run_rows(40);

        settle();
        write_mode(MODE_PASS);
        run_rows(60);
        settle();
        write_mode(MODE_COLLAPSE);

        // One glyph that spans a long row, with the cursor at the far end, keeps every
        // counter climbing until the row closes.
        send_cell(16'h5B57, LEAD_MASK, 1'b0, 1'b1, 12'hFFF);
        for (int i = 1; i < LONG_ROW_CELLS; i++)
            send_cell(t_char'($urandom), t_attr'($urandom) & ~TRAIL_MASK,
                      i == LONG_ROW_CELLS - 1, 1'b1, 12'hFFF);

        run_rows(120);
        quiet = 1'b1;
        run_rows(60);
        settle();
        run_tracker.flush_leftovers();
        if (run_tracker.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
